FILE: rtl/pngasf_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG adaptive scanline filter.
// Used by png_adaptive_scanline_filter; no dependencies.

package pngasf_pkg;

	localparam int ROW_MAX    = 8192;
	localparam int ROW_AW     = $clog2(ROW_MAX);
	localparam int POS_W      = ROW_AW + 1;
	localparam int LEN_W      = 14;
	localparam int BPP_W      = 3;
	localparam int CMP_W      = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int COST_W     = 21;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LEN_W;
	localparam int NUM_FILT   = 5;

	localparam logic [COST_W-1:0]    COST_MAX      = {COST_W{1'b1}};
	localparam logic [LEN_W-1:0]     ROW_LEN_RESET = LEN_W'(ROW_MAX);
	localparam logic [BPP_W-1:0]     BPP_RGB       = 3'd3;
	localparam logic [BPP_W-1:0]     BPP_RGBA      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = 1'b1;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LOAD,
		KIND_TYPE,
		KIND_DATA
	} item_kind_t;

	typedef enum logic [2:0] {
		FLT_NONE,
		FLT_SUB,
		FLT_UP,
		FLT_AVG,
		FLT_PAETH
	} filter_t;

	typedef struct packed {
		logic       last;
		logic       is_type;
		logic [7:0] data;
	} out_item_t;

	function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [10:0] d_bc;
		logic [10:0] d_ac;
		logic [10:0] d_p;
		logic [10:0] pa;
		logic [10:0] pb;
		logic [10:0] pc;
		logic [7:0]  pred;
		d_bc = {3'b000, b} - {3'b000, c};
		d_ac = {3'b000, a} - {3'b000, c};
		d_p  = {3'b000, a} + {3'b000, b} - {2'b00, c, 1'b0};
		pa   = d_bc[10] ? (11'd0 - d_bc) : d_bc;
		pb   = d_ac[10] ? (11'd0 - d_ac) : d_ac;
		pc   = d_p[10] ? (11'd0 - d_p) : d_p;
		if (pa <= pb && pa <= pc) begin
			pred = a;
		end else if (pb <= pc) begin
			pred = b;
		end else begin
			pred = c;
		end
		return pred;
	endfunction

	function automatic logic [7:0] cost_mag(input logic [7:0] v);
		return v[7] ? (8'd0 - v) : v;
	endfunction

endpackage

FILE: rtl/pngasf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.

module pngasf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/png_adaptive_scanline_filter.sv
// Top level of the PNG adaptive scanline filter: loads a row, costs all five filters,
// then drains the cheapest filter's type byte and the refiltered row.
// Depends on pngasf_pkg and pngasf_ram.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: pixel_byte; tuser: mode, image_start
// m_*       out        m_tvalid / m_tready  tdata: out_byte; tuser: is_filter_type; tlast
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle while s_tready is high; a drain result passes through stages 1 to 4
// and the output queue before it is presented at the output.
// Each drained byte is copied into the up-row RAM in the cycle after it is read, and a read of
// that address in the same cycle takes the copied byte directly.
// s_tready drops only when eight results are already in flight or queued at the output.
// Reset clears all control state; the row RAMs hold undefined data until written.

module png_adaptive_scanline_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] pixel_byte
	input  logic [1:0]                          s_tuser,   // [0] mode, [1] image_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // [7:0] out_byte
	output logic                                m_tuser,   // [0] is_filter_type
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pngasf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pngasf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import pngasf_pkg::*;

	logic [LEN_W-1:0]   row_length_q;
	logic [BPP_W-1:0]   bpp_q;
	logic [CMP_W-1:0]   len_ext;
	logic [POS_W-1:0]   eff_len;
	logic               bpp4;

	logic [ROW_AW-1:0]  load_pos_q;
	logic [POS_W-1:0]   drain_pos_q;
	logic [POS_W-1:0]   drain_dec;
	logic [ROW_AW-1:0]  drain_j;
	logic               row_ready_q;
	logic               up_valid_q;
	logic               up_valid_ld;

	logic               s_acc;
	logic               mode;
	logic               load_go;
	logic               drain_go;
	logic               load_done;
	logic               drain_first;
	logic               drain_last;
	logic [ROW_AW-1:0]  raddr;
	logic [7:0]         cur_rdata;
	logic [7:0]         up_rdata;

	item_kind_t         kind_s1;
	logic [7:0]         x_s1;
	logic               pos0_s1;
	logic               upv_s1;
	logic               bpp4_s1;
	logic [ROW_AW-1:0]  j_s1;
	logic               done_s1;
	logic               last_s1;
	logic [7:0]         hcur_q [4];
	logic [7:0]         hup_q [4];
	logic [7:0]         hc_m [4];
	logic [7:0]         hu_m [4];
	logic [7:0]         cur_rd;
	logic [7:0]         up_rd;
	logic [7:0]         xv;
	logic [7:0]         av;
	logic [7:0]         bv;
	logic [7:0]         cv;
	logic               hist_en;
	logic               up_we;
	logic               byp_q;
	logic [7:0]         byp_data_q;

	item_kind_t         kind_s2;
	logic [7:0]         x_s2;
	logic [7:0]         a_s2;
	logic [7:0]         b_s2;
	logic [7:0]         c_s2;
	logic               done_s2;
	logic               last_s2;
	logic [8:0]         avg_sum;
	logic [7:0]         filt [NUM_FILT];

	item_kind_t         kind_s3;
	logic [7:0]         filt_s3 [NUM_FILT];
	logic [7:0]         mag_s3 [NUM_FILT];
	logic               done_s3;
	logic               last_s3;

	item_kind_t         kind_s4;
	logic [7:0]         filt_s4 [NUM_FILT];
	logic               last_s4;

	logic [COST_W-1:0]  costs_q [NUM_FILT];
	logic [COST_W:0]    cost_sum [NUM_FILT];
	logic               pick_q;
	filter_t            chosen_q;
	filter_t            best;

	out_item_t          fifo_q [FIFO_DEPTH];
	out_item_t          push_item;
	out_item_t          head;
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   fcnt_q;
	logic [FIFO_AW:0]   pend_q;
	logic               push;
	logic               pop;

	// Configuration registers and their effective values.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LEN_RESET;
			bpp_q        <= BPP_RGBA;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data[LEN_W-1:0];
				REG_BPP:        bpp_q        <= cfg_data[BPP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		len_ext = CMP_W'(row_length_q);
		if (len_ext == '0) begin
			eff_len = POS_W'(1);
		end else if (len_ext > CMP_W'(ROW_MAX)) begin
			eff_len = POS_W'(ROW_MAX);
		end else begin
			eff_len = POS_W'(len_ext);
		end
	end

	assign bpp4 = (bpp_q > BPP_RGB);

	// Request decode and row control.
	assign s_acc       = s_tvalid && s_tready;
	assign mode        = s_tuser[0];
	assign load_go     = s_acc && !mode && !row_ready_q;
	assign drain_go    = s_acc && mode && row_ready_q;
	assign load_done   = (POS_W'(load_pos_q) + POS_W'(1)) >= eff_len;
	assign drain_first = (drain_pos_q == '0);
	assign drain_last  = !drain_first && (drain_pos_q >= eff_len);
	assign drain_dec   = drain_pos_q - POS_W'(1);
	assign drain_j     = drain_dec[ROW_AW-1:0];
	assign up_valid_ld = (load_pos_q == '0 && s_tuser[1]) ? 1'b0 : up_valid_q;
	assign raddr       = mode ? drain_j : load_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			drain_pos_q <= '0;
			row_ready_q <= 1'b0;
			up_valid_q  <= 1'b0;
		end else begin
			if (load_go) begin
				up_valid_q <= up_valid_ld;
				if (load_done) begin
					load_pos_q  <= '0;
					drain_pos_q <= '0;
					row_ready_q <= 1'b1;
				end else begin
					load_pos_q <= load_pos_q + ROW_AW'(1);
				end
			end
			if (drain_go) begin
				if (drain_first) begin
					drain_pos_q <= POS_W'(1);
				end else if (drain_last) begin
					drain_pos_q <= '0;
					row_ready_q <= 1'b0;
					up_valid_q  <= 1'b1;
				end else begin
					drain_pos_q <= drain_pos_q + POS_W'(1);
				end
			end
		end
	end

	pngasf_ram #(.WIDTH(8), .DEPTH(ROW_MAX)) u_cur_row (
		.clk   (clk),
		.we    (load_go),
		.waddr (load_pos_q),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (cur_rdata)
	);

	pngasf_ram #(.WIDTH(8), .DEPTH(ROW_MAX)) u_up_row (
		.clk   (clk),
		.we    (up_we),
		.waddr (j_s1),
		.wdata (cur_rd),
		.raddr (raddr),
		.rdata (up_rdata)
	);

	// Stage 1: row data arrives from RAM, neighbours come from the byte history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_NONE;
		end else if (load_go) begin
			kind_s1 <= KIND_LOAD;
		end else if (drain_go) begin
			kind_s1 <= drain_first ? KIND_TYPE : KIND_DATA;
		end else begin
			kind_s1 <= KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= s_tdata;
		pos0_s1 <= mode ? (drain_pos_q == POS_W'(1)) : (load_pos_q == '0);
		upv_s1  <= mode ? up_valid_q : up_valid_ld;
		bpp4_s1 <= bpp4;
		j_s1    <= raddr;
		done_s1 <= load_done;
		last_s1 <= drain_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= up_we && (j_s1 == raddr);
		end
	end

	always_comb begin
		cur_rd  = cur_rdata;
		up_rd   = byp_q ? byp_data_q : up_rdata;
		up_we   = (kind_s1 == KIND_DATA);
		xv      = (kind_s1 == KIND_LOAD) ? x_s1 : cur_rd;
		bv      = upv_s1 ? up_rd : 8'd0;
		for (int k = 0; k < 4; k++) begin
			hc_m[k] = pos0_s1 ? 8'd0 : hcur_q[k];
			hu_m[k] = pos0_s1 ? 8'd0 : hup_q[k];
		end
		av      = bpp4_s1 ? hc_m[3] : hc_m[2];
		cv      = bpp4_s1 ? hu_m[3] : hu_m[2];
		hist_en = (kind_s1 == KIND_LOAD) || (kind_s1 == KIND_DATA);
	end

	always_ff @(posedge clk) begin
		if (hist_en) begin
			hcur_q[0] <= xv;
			hup_q[0]  <= bv;
			for (int k = 1; k < 4; k++) begin
				hcur_q[k] <= hc_m[k-1];
				hup_q[k]  <= hu_m[k-1];
			end
		end
		byp_data_q <= cur_rd;
		x_s2    <= xv;
		a_s2    <= av;
		b_s2    <= bv;
		c_s2    <= cv;
		done_s2 <= done_s1;
		last_s2 <= last_s1;
	end

	// Stage 2: all five filters and their cost magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s2 <= KIND_NONE;
			kind_s3 <= KIND_NONE;
			kind_s4 <= KIND_NONE;
		end else begin
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
		end
	end

	always_comb begin
		avg_sum         = {1'b0, a_s2} + {1'b0, b_s2};
		filt[FLT_NONE]  = x_s2;
		filt[FLT_SUB]   = x_s2 - a_s2;
		filt[FLT_UP]    = x_s2 - b_s2;
		filt[FLT_AVG]   = x_s2 - avg_sum[8:1];
		filt[FLT_PAETH] = x_s2 - paeth_pred(a_s2, b_s2, c_s2);
	end

	always_ff @(posedge clk) begin
		for (int f = 0; f < NUM_FILT; f++) begin
			filt_s3[f] <= filt[f];
			mag_s3[f]  <= cost_mag(filt[f]);
			filt_s4[f] <= filt_s3[f];
		end
		done_s3 <= done_s2;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
	end

	// Stage 3: cost accumulation; the best filter is picked in the cycle after a row completes.
	always_comb begin
		for (int f = 0; f < NUM_FILT; f++) begin
			cost_sum[f] = {1'b0, costs_q[f]} + (COST_W + 1)'(mag_s3[f]);
		end
		best = FLT_NONE;
		for (int f = 1; f < NUM_FILT; f++) begin
			if (costs_q[f] < costs_q[best]) begin
				best = filter_t'(3'(f));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < NUM_FILT; f++) begin
				costs_q[f] <= '0;
			end
			pick_q   <= 1'b0;
			chosen_q <= FLT_NONE;
		end else begin
			pick_q <= (kind_s3 == KIND_LOAD) && done_s3;
			if (pick_q) begin
				chosen_q <= best;
				for (int f = 0; f < NUM_FILT; f++) begin
					costs_q[f] <= '0;
				end
			end else if (kind_s3 == KIND_LOAD) begin
				for (int f = 0; f < NUM_FILT; f++) begin
					costs_q[f] <= cost_sum[f][COST_W] ? COST_MAX : cost_sum[f][COST_W-1:0];
				end
			end
		end
	end

	// Stage 4: select the drained byte and queue it for the output.
	always_comb begin
		push              = (kind_s4 == KIND_TYPE) || (kind_s4 == KIND_DATA);
		push_item.is_type = (kind_s4 == KIND_TYPE);
		push_item.last    = (kind_s4 == KIND_DATA) && last_s4;
		if (kind_s4 == KIND_TYPE) begin
			push_item.data = 8'(chosen_q);
		end else begin
			case (chosen_q)
				FLT_NONE:  push_item.data = filt_s4[FLT_NONE];
				FLT_SUB:   push_item.data = filt_s4[FLT_SUB];
				FLT_UP:    push_item.data = filt_s4[FLT_UP];
				FLT_AVG:   push_item.data = filt_s4[FLT_AVG];
				FLT_PAETH: push_item.data = filt_s4[FLT_PAETH];
				default:   push_item.data = filt_s4[FLT_NONE];
			endcase
		end
	end

	assign head     = fifo_q[rptr_q];
	assign m_tvalid = (fcnt_q != '0);
	assign m_tdata  = head.data;
	assign m_tuser  = head.is_type;
	assign m_tlast  = head.last;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (pend_q < (FIFO_AW + 1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			fcnt_q <= fcnt_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
			pend_q <= pend_q + (FIFO_AW + 1)'(drain_go) - (FIFO_AW + 1)'(pop);
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("more results outstanding than the output queue holds");

	a_queue_in_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= pend_q)
		else $error("output queue holds a result that was never requested");

	a_ready_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		row_ready_q |-> (load_pos_q == '0))
		else $error("load position not cleared while a row awaits draining");

	a_drain_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_pos_q != '0) |-> row_ready_q)
		else $error("drain position moved with no row ready");

	a_pick_alone: assert property (@(posedge clk) disable iff (!arst_n)
		pick_q |-> (kind_s3 != KIND_LOAD))
		else $error("cost update collides with the filter pick");

	a_row_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_go && drain_last) |=> (up_valid_q && !row_ready_q))
		else $error("finished row did not become the up row");

endmodule
